>>> rtl/lcvs_pkg.sv
// Shared types, action codes and helpers for the LED cube voxel store.
`default_nettype none
package lcvs_pkg;

  localparam int unsigned ROW_W      = 8;
  localparam int unsigned CUBE_DEPTH = 64;
  localparam int unsigned ADDR_W     = $clog2(CUBE_DEPTH);
  localparam int unsigned CNT_W      = 4;
  localparam logic [CNT_W-1:0] SCAN_LAST = 4'd9;

  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_CLR   = 3'd1;
  localparam logic [2:0] ACT_GET   = 3'd2;
  localparam logic [2:0] ACT_CLRALL = 3'd3;
  localparam logic [2:0] ACT_SCAN  = 3'd4;
  localparam logic [2:0] ACT_BLANK = 3'd5;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_SHIFT = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] col_x;
    logic [2:0] row_y;
    logic [2:0] layer_z;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } rsp_t;

  function automatic logic [7:0] onehot8(input logic [2:0] sel);
    logic [7:0] r;
    r = 8'd0;
    r[sel] = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lcvs_stream_if.sv
// Valid/ready stream channel with a typed payload.
`default_nettype none
interface lcvs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/led_cube_voxel_store_scanout_core.sv
// LED cube 8x8x8 voxel store with serial layer scan-out (top level).
//
// Channels: cmd (sink) takes one action per transfer: set, clear or get a
// voxel, clear the whole cube, scan a layer or blank. rsp (source) gives
// voxel read replies (kind 0) and shift bytes (kind 1, bit 0 shifted first,
// last marks the latch pulse).
// Row bytes live in a 64x8 RAM addressed {layer, row}; 64 valid bits mark
// rows written since reset or clear-all, an unmarked row reads as zero.
// Steps per action after the cmd transfer:
//   clear all : valid bits cleared at the transfer, no result.
//   set/clear : read, then modify and write back; no result.
//   get       : reply loaded into the output register once it is free.
//   scan/blank: 10 bytes, one per cycle while the receiver takes them; the
//               next cmd is taken the cycle after the last byte is loaded.
//   The single RAM port sets the pace: one row read per output byte.
// Reset clears the valid bits at once (cube dark) and idles the control.
// A stalled receiver holds the output register and freezes the byte
// counter; the cmd side takes new actions while a reply still waits.
`default_nettype none
module led_cube_voxel_store_scanout_core
  import lcvs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  lcvs_stream_if.sink   cmd,
  lcvs_stream_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RMW  = 4'b0010,
    S_GET  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        x_q;
  logic [2:0]        z_q;
  logic              set_q;
  logic              blank_q;

  logic [CUBE_DEPTH-1:0] valid;
  logic                  valid_r;

  logic              out_valid;
  rsp_t              out_data;
  logic              out_free;
  logic              out_load;
  rsp_t              load_data;

  logic              cmd_xfer;
  cmd_t              cmd_pl;
  logic              clr_all;

  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_data;
  logic [2:0]        cur_row;
  logic [2:0]        nxt_row;
  logic [ROW_W-1:0]  emit_byte;
  logic [ROW_W-1:0]  bit_mask;

  assign cmd_pl    = cmd.payload;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign clr_all   = cmd_xfer && (cmd_pl.action == ACT_CLRALL);

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;
  assign out_free    = !out_valid || rsp.ready;

  // rows that were never written (or cleared) read as a dark row
  assign row_data = valid_r ? ram_rdata : '0;

  // byte 2 carries row 7, byte 9 carries row 0
  assign cur_row = 3'(4'd9 - cnt);
  assign nxt_row = 3'(4'd9 - cnt_next);

  assign bit_mask  = onehot8(x_q);
  assign ram_we    = (state == S_RMW);
  assign ram_wdata = set_q ? (row_data | bit_mask) : (row_data & ~bit_mask);

  always_comb begin
    if (blank_q) begin
      emit_byte = '0;
    end else if (cnt == 4'd0) begin
      emit_byte = onehot8(z_q);
    end else if (cnt == 4'd1) begin
      emit_byte = '0;
    end else if (cur_row[0]) begin
      emit_byte = bit_rev8(row_data);
    end else begin
      emit_byte = row_data;
    end
  end

  // Sequencer. The RAM address is taken from the next counter value so the
  // row for the byte on deck is already in the read register.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    out_load   = 1'b0;
    load_data  = '{kind: KIND_REPLY, value: '0, last: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          unique case (cmd_pl.action)
            ACT_SET, ACT_CLR: state_next = S_RMW;
            ACT_GET:          state_next = S_GET;
            ACT_SCAN, ACT_BLANK: begin
              state_next = S_EMIT;
              cnt_next   = '0;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RMW: begin
        state_next = S_IDLE;
      end
      S_GET: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_data  = '{kind: KIND_REPLY, value: {7'd0, row_data[x_q]}, last: 1'b0};
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_data = '{kind: KIND_SHIFT, value: emit_byte, last: (cnt == SCAN_LAST)};
          cnt_next  = cnt + 1'b1;
          if (cnt == SCAN_LAST) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:       ram_addr = {cmd_pl.layer_z, cmd_pl.row_y};
      S_RMW, S_GET: ram_addr = addr_q;
      S_EMIT:       ram_addr = {z_q, nxt_row};
      default:      ram_addr = addr_q;
    endcase
  end

  lcvs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CUBE_DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      valid     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (clr_all) begin
        valid <= '0;
      end else if (ram_we) begin
        valid[addr_q] <= 1'b1;
      end
    end
  end

  // payload and operand registers
  always_ff @(posedge clk) begin
    valid_r <= valid[ram_addr];
    if (cmd_xfer) begin
      addr_q  <= {cmd_pl.layer_z, cmd_pl.row_y};
      x_q     <= cmd_pl.col_x;
      z_q     <= cmd_pl.layer_z;
      set_q   <= (cmd_pl.action == ACT_SET);
      blank_q <= (cmd_pl.action == ACT_BLANK);
    end
    if (out_load) begin
      out_data <= load_data;
    end
  end

  // a scan or blank starts at byte zero the cycle after its transfer
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_xfer && (cmd_pl.action == ACT_SCAN || cmd_pl.action == ACT_BLANK))
      |=> (state == S_EMIT && cnt == 4'd0))
    else $error("scan did not start at byte zero");

  // the byte counter never runs past the latch byte while emitting
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (cnt <= SCAN_LAST))
    else $error("scan byte counter out of range");

  // a write back marks its row valid
  a_wb_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(addr_q)])
    else $error("written row not marked valid");

  // the latch byte is a shift byte and ends the scan
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && load_data.last) |=> (state == S_IDLE && rsp.payload.kind == KIND_SHIFT))
    else $error("latch flag outside a shift sequence end");

  // voxel replies carry a single bit
  a_reply_bit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.kind == KIND_REPLY) |-> (rsp.payload.value[7:1] == 7'd0))
    else $error("voxel reply wider than one bit");

endmodule
`default_nettype wire

>>> rtl/lcvs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module lcvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> tb/led_cube_voxel_store_scanout_core_test.sv
// Self-checking testbench for the LED cube voxel store and layer scan-out core.
`timescale 1ns / 1ps
module led_cube_voxel_store_scanout_core_test;
  import lcvs_pkg::*;

  // Action codes the block must ignore (no result, no state change).
  localparam logic [2:0] ACT_UNUSED_A = 3'd6;
  localparam logic [2:0] ACT_UNUSED_B = 3'd7;

  localparam int HOLD_CYCLES   = 150;  // long receiver hold-off in the last phase
  localparam int NO_TYPED_BIT  = -1;   // directed row checked by the predictor only
  localparam int SCAN_BYTES    = 10;

  logic clk;
  logic rst;

  lcvs_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  lcvs_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  led_cube_voxel_store_scanout_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the cube: one byte per {layer, row}, bit x is column x.
  logic [7:0] cube_rows [CUBE_DEPTH];
  // Results still owed by the block, oldest first.
  rsp_t       awaited_rsp [$];

  // Directed plan: command plus, for a get, the voxel bit typed in by hand.
  cmd_t       plan_cmd [$];
  int         plan_bit [$];

  int         error_count   = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_request  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void owe_shift(input logic [7:0] data, input logic is_last);
    rsp_t r;
    r.kind  = KIND_SHIFT;
    r.value = data;
    r.last  = is_last;
    awaited_rsp.push_back(r);
  endfunction

  // Apply one accepted action to the shadow cube and queue what it must emit.
  function automatic void cube_apply(input cmd_t c);
    logic [ADDR_W-1:0] idx;
    logic [7:0]        row;
    logic [7:0]        flip;
    rsp_t              r;
    idx = {c.layer_z, c.row_y};
    case (c.action)
      ACT_SET: cube_rows[idx][c.col_x] = 1'b1;
      ACT_CLR: cube_rows[idx][c.col_x] = 1'b0;
      ACT_GET: begin
        r.kind  = KIND_REPLY;
        r.value = {7'd0, cube_rows[idx][c.col_x]};
        r.last  = 1'b0;
        awaited_rsp.push_back(r);
      end
      ACT_CLRALL: begin
        for (int i = 0; i < CUBE_DEPTH; i++) cube_rows[i] = 8'd0;
      end
      ACT_SCAN: begin
        // layer select, spacer, then rows 7 down to 0
        owe_shift(8'd1 << c.layer_z, 1'b0);
        owe_shift(8'd0, 1'b0);
        for (int k = 7; k >= 0; k--) begin
          row = cube_rows[{c.layer_z, 3'(k)}];
          if (k % 2 == 1) begin
            // odd rows leave MSB first
            for (int b = 0; b < 8; b++) flip[b] = row[7-b];
            row = flip;
          end
          owe_shift(row, k == 0);
        end
      end
      ACT_BLANK: begin
        for (int n = 0; n < SCAN_BYTES; n++) owe_shift(8'd0, n == SCAN_BYTES - 1);
      end
      default: ;
    endcase
  endfunction

  function automatic void plan_row(input logic [2:0] act, input logic [2:0] x,
                                   input logic [2:0] y, input logic [2:0] z,
                                   input int typed_bit);
    cmd_t c;
    c.action  = act;
    c.col_x   = x;
    c.row_y   = y;
    c.layer_z = z;
    plan_cmd.push_back(c);
    plan_bit.push_back(typed_bit);
  endfunction

  // Sets are the most frequent action so scans see a busy cube; clear-all kept rare.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    pick      = $urandom_range(99);
    c.col_x   = 3'($urandom_range(7));
    c.row_y   = 3'($urandom_range(7));
    c.layer_z = 3'($urandom_range(7));
    if (pick < 36)      c.action = ACT_SET;
    else if (pick < 50) c.action = ACT_CLR;
    else if (pick < 74) c.action = ACT_GET;
    else if (pick < 88) c.action = ACT_SCAN;
    else if (pick < 92) c.action = ACT_BLANK;
    else if (pick < 94) c.action = ACT_CLRALL;
    else if (pick < 97) c.action = ACT_UNUSED_A;
    else                c.action = ACT_UNUSED_B;
    return c;
  endfunction

  // Offer one command, wait for the transfer, then predict its results.
  task automatic issue(input cmd_t c, input int typed_bit);
    rsp_t fixed;
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    cube_apply(c);
    if (typed_bit != NO_TYPED_BIT) begin
      fixed.kind  = KIND_REPLY;
      fixed.value = 8'(typed_bit);
      fixed.last  = 1'b0;
      awaited_rsp[awaited_rsp.size() - 1] = fixed;
    end
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) issue(random_cmd(), NO_TYPED_BIT);
  endtask

  // Receiver: random back-pressure, or one long hold-off when asked.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%02h last %0d",
               rsp_ch.payload.kind, rsp_ch.payload.value, rsp_ch.payload.last);
        error_count++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_ch.payload.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, rsp_ch.payload.kind);
          error_count++;
        end
        if (rsp_ch.payload.value !== want.value) begin
          $error("value: expected 0x%02h, got 0x%02h", want.value, rsp_ch.payload.value);
          error_count++;
        end
        if (rsp_ch.payload.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_ch.payload.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CUBE_DEPTH; i++) cube_rows[i] = 8'd0;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;

    // Directed rows; the typed bit is the get reply known without the predictor.
    plan_row(ACT_GET,      3'd0, 3'd0, 3'd0, 0);             // dark after reset
    plan_row(ACT_GET,      3'd7, 3'd7, 3'd7, 0);
    plan_row(ACT_SCAN,     3'd0, 3'd0, 3'd0, NO_TYPED_BIT);  // dark layer, select bit 0
    plan_row(ACT_BLANK,    3'd0, 3'd0, 3'd0, NO_TYPED_BIT);
    plan_row(ACT_SET,      3'd7, 3'd7, 3'd7, NO_TYPED_BIT);
    plan_row(ACT_GET,      3'd7, 3'd7, 3'd7, 1);
    plan_row(ACT_SET,      3'd0, 3'd0, 3'd0, NO_TYPED_BIT);
    plan_row(ACT_SET,      3'd0, 3'd1, 3'd0, NO_TYPED_BIT);  // odd row, comes out reversed
    plan_row(ACT_SET,      3'd7, 3'd6, 3'd0, NO_TYPED_BIT);
    plan_row(ACT_SET,      3'd3, 3'd5, 3'd0, NO_TYPED_BIT);
    plan_row(ACT_SCAN,     3'd0, 3'd0, 3'd0, NO_TYPED_BIT);
    plan_row(ACT_SCAN,     3'd0, 3'd0, 3'd7, NO_TYPED_BIT);  // top layer, select bit 7
    plan_row(ACT_CLR,      3'd7, 3'd7, 3'd7, NO_TYPED_BIT);
    plan_row(ACT_GET,      3'd7, 3'd7, 3'd7, 0);
    plan_row(ACT_UNUSED_A, 3'd5, 3'd5, 3'd5, NO_TYPED_BIT);  // ignored codes
    plan_row(ACT_UNUSED_B, 3'd2, 3'd2, 3'd2, NO_TYPED_BIT);
    plan_row(ACT_GET,      3'd0, 3'd0, 3'd0, 1);
    plan_row(ACT_CLRALL,   3'd0, 3'd0, 3'd0, NO_TYPED_BIT);
    plan_row(ACT_GET,      3'd0, 3'd0, 3'd0, 0);
    plan_row(ACT_SCAN,     3'd0, 3'd0, 3'd0, NO_TYPED_BIT);
    plan_row(ACT_SET,      3'd5, 3'd2, 3'd3, NO_TYPED_BIT);
    plan_row(ACT_GET,      3'd5, 3'd2, 3'd3, 1);
    plan_row(ACT_SCAN,     3'd0, 3'd0, 3'd3, NO_TYPED_BIT);
    plan_row(ACT_BLANK,    3'd7, 3'd7, 3'd7, NO_TYPED_BIT);

    // Phase A: sender idles 32%, receiver 53%.
    send_idle_pct = 32;
    recv_idle_pct = 53;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < plan_cmd.size(); i++) issue(plan_cmd[i], plan_bit[i]);
    random_phase(140);

    // Phase B: the other way round.
    send_idle_pct = 53;
    recv_idle_pct = 32;
    random_phase(140);

    // Phase C: no idling; the receiver first holds off long enough that the
    // block fills and stalls the command side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    random_phase(130);

    cmd_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lcvs_pkg.sv
rtl/lcvs_stream_if.sv
rtl/lcvs_ram.sv
rtl/led_cube_voxel_store_scanout_core.sv
tb/led_cube_voxel_store_scanout_core_test.sv
